>>> hdl/tste_pkg.sv
package tste_pkg;

  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned FLD_W       = 7;
  localparam int unsigned EPOCH_W     = 39;
  localparam int unsigned DATE_DIGITS = 14;
  localparam int unsigned ZONE_DIGITS = 4;
  localparam int unsigned NUM_STAGES  = 8;

  typedef enum logic [2:0] {
    PH_DATE,
    PH_GAP,
    PH_ZONE,
    PH_ZDONE,
    PH_NOZONE,
    PH_BAD
  } tste_phase_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [FLD_W-1:0]  month;
    logic [FLD_W-1:0]  day;
    logic [FLD_W-1:0]  hour;
    logic [FLD_W-1:0]  minute;
    logic [FLD_W-1:0]  second;
    logic [FLD_W-1:0]  zone_hours;
    logic [FLD_W-1:0]  zone_minutes;
    logic              zone_negative;
    logic              zone_used;
    logic              matched;
  } tste_fields_t;

  function automatic logic [8:0] days_before(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // floor(m / 12) for m below 128
  function automatic logic [3:0] div12(input logic [6:0] m);
    logic [14:0] p;
    p = 15'(m) * 15'd171;
    return p[14:11];
  endfunction

  function automatic logic [14:0] div100(input logic [14:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'd41944;
    return 15'(p[30:22]);
  endfunction

  function automatic logic [14:0] div400(input logic [14:0] x);
    logic [30:0] p;
    p = 31'(x) * 31'd41944;
    return 15'(p[30:24]);
  endfunction

  function automatic logic [14:0] magnitude(input logic signed [15:0] x);
    logic signed [15:0] n;
    n = -x;
    return x[15] ? n[14:0] : x[14:0];
  endfunction

  function automatic logic signed [15:0] apply_sign(input logic neg, input logic [14:0] q);
    logic signed [15:0] s;
    s = signed'({1'b0, q});
    return neg ? -s : s;
  endfunction

  // quotients truncated toward zero
  function automatic logic signed [15:0] tdiv4(input logic signed [15:0] x);
    logic [14:0] m;
    m = magnitude(x);
    return apply_sign(x[15], m >> 2);
  endfunction

  function automatic logic signed [15:0] tdiv100(input logic signed [15:0] x);
    return apply_sign(x[15], div100(magnitude(x)));
  endfunction

  function automatic logic signed [15:0] tdiv400(input logic signed [15:0] x);
    return apply_sign(x[15], div400(magnitude(x)));
  endfunction

endpackage

>>> hdl/tste_parse.sv
module tste_parse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            char_in,
  input  logic                  last,
  output tste_pkg::tste_fields_t fld
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned YW = tste_pkg::YEAR_W;
  localparam int unsigned FW = tste_pkg::FLD_W;

  tste_pkg::tste_phase_t phase_r, phase_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [YW-1:0] year_r, year_nxt;
  logic [FW-1:0] month_r, month_nxt;
  logic [FW-1:0] day_r, day_nxt;
  logic [FW-1:0] hour_r, hour_nxt;
  logic [FW-1:0] minute_r, minute_nxt;
  logic [FW-1:0] second_r, second_nxt;
  logic [FW-1:0] zh_r, zh_nxt;
  logic [FW-1:0] zm_r, zm_nxt;
  logic          zneg_r, zneg_nxt;

  logic       is_digit;
  logic       is_space;
  logic [7:0] dfull;
  logic [3:0] d;

  function automatic logic [FW-1:0] push7(input logic [FW-1:0] acc, input logic [3:0] dig);
    return FW'(acc * FW'(10)) + FW'(dig);
  endfunction

  always_comb begin
    is_digit = char_in inside {[CH_ZERO:CH_NINE]};
    is_space = char_in inside {CH_SPACE, [CH_TAB:CH_CR]};
    dfull    = char_in - CH_ZERO;
    d        = is_digit ? dfull[3:0] : 4'd0;

    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    zh_nxt     = zh_r;
    zm_nxt     = zm_r;
    zneg_nxt   = zneg_r;

    case (phase_r)
      tste_pkg::PH_DATE: begin
        if (!is_digit) begin
          phase_nxt = tste_pkg::PH_BAD;
        end else begin
          if (idx_r < 4'd4) begin
            year_nxt = YW'(year_r * YW'(10)) + YW'(d);
          end else if (idx_r < 4'd6) begin
            month_nxt = push7(month_r, d);
          end else if (idx_r < 4'd8) begin
            day_nxt = push7(day_r, d);
          end else if (idx_r < 4'd10) begin
            hour_nxt = push7(hour_r, d);
          end else if (idx_r < 4'd12) begin
            minute_nxt = push7(minute_r, d);
          end else begin
            second_nxt = push7(second_r, d);
          end
          if (idx_r == 4'(tste_pkg::DATE_DIGITS - 1)) begin
            idx_nxt   = 4'd0;
            phase_nxt = tste_pkg::PH_GAP;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      tste_pkg::PH_GAP: begin
        if (char_in == CH_PLUS || char_in == CH_MINUS) begin
          zneg_nxt  = (char_in == CH_MINUS);
          idx_nxt   = 4'd0;
          phase_nxt = tste_pkg::PH_ZONE;
        end else if (!is_space) begin
          phase_nxt = tste_pkg::PH_NOZONE;
        end
      end
      tste_pkg::PH_ZONE: begin
        if (!is_digit) begin
          phase_nxt = tste_pkg::PH_NOZONE;
        end else begin
          if (idx_r < 4'd2) begin
            zh_nxt = push7(zh_r, d);
          end else begin
            zm_nxt = push7(zm_r, d);
          end
          idx_nxt = idx_r + 4'd1;
          if (idx_r == 4'(tste_pkg::ZONE_DIGITS - 1)) begin
            phase_nxt = tste_pkg::PH_ZDONE;
          end
        end
      end
      default: begin
      end
    endcase

    fld.year          = year_nxt;
    fld.month         = month_nxt;
    fld.day           = day_nxt;
    fld.hour          = hour_nxt;
    fld.minute        = minute_nxt;
    fld.second        = second_nxt;
    fld.zone_hours    = zh_nxt;
    fld.zone_minutes  = zm_nxt;
    fld.zone_negative = zneg_nxt;
    fld.zone_used     = (phase_nxt == tste_pkg::PH_ZDONE);
    fld.matched       = !(phase_nxt == tste_pkg::PH_DATE || phase_nxt == tste_pkg::PH_BAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      phase_r  <= tste_pkg::PH_DATE;
      idx_r    <= '0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      zh_r     <= '0;
      zm_r     <= '0;
      zneg_r   <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      zh_r     <= zh_nxt;
      zm_r     <= zm_nxt;
      zneg_r   <= zneg_nxt;
    end
  end

endmodule

>>> hdl/tste_calc.sv
module tste_calc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  tste_pkg::tste_fields_t               fld,
  output logic                                 ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tste_pkg::EPOCH_W-1:0]         epoch,
  output logic                                 matched
);

  localparam int unsigned N  = tste_pkg::NUM_STAGES;
  localparam int unsigned FW = tste_pkg::FLD_W;
  localparam int unsigned EW = tste_pkg::EPOCH_W;

  logic [N-1:0] vld_r, vld_nxt, adv, free, ld;

  always_comb begin
    adv[N-1]  = vld_r[N-1] & out_ready;
    free[N-1] = ~vld_r[N-1] | adv[N-1];
    for (int i = N - 2; i >= 0; i--) begin
      adv[i]  = vld_r[i] & free[i+1];
      free[i] = ~vld_r[i] | adv[i];
    end
    ld      = {adv[N-2:0], load};
    vld_nxt = ld | (vld_r & ~adv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ready     = free[0];
  assign out_valid = vld_r[N-1];

  // stage 0: captured fields
  tste_pkg::tste_fields_t s0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_r <= fld;
    end
  end

  // stage 1: month normalisation, zone offset
  logic signed [15:0] yr1_r, yl1_r;
  logic [3:0]         mon1_r;
  logic signed [19:0] off1_r;
  logic [FW-1:0]      day1_r, hour1_r, min1_r, sec1_r;
  logic               m1_r;

  logic [6:0]         m_c;
  logic [3:0]         q12_c;
  logic [6:0]         r12_c;
  logic signed [15:0] yr_c, yl_c;
  logic [3:0]         mon_c;
  logic [18:0]        offm_c;
  logic signed [19:0] offs_c, off_c;

  always_comb begin
    m_c   = s0_r.month - 7'd1;
    q12_c = tste_pkg::div12(m_c);
    r12_c = m_c - 7'(7'(q12_c) * 7'd12);
    if (s0_r.month == 7'd0) begin
      yr_c  = signed'({2'b00, s0_r.year}) - 16'sd1;
      mon_c = 4'd11;
    end else begin
      yr_c  = signed'({2'b00, s0_r.year}) + signed'({12'd0, q12_c});
      mon_c = r12_c[3:0];
    end
    yl_c   = (mon_c <= 4'd1) ? yr_c - 16'sd1 : yr_c;
    offm_c = 19'(s0_r.zone_hours) * 19'd3600 + 19'(s0_r.zone_minutes) * 19'd60;
    offs_c = signed'({1'b0, offm_c});
    if (!s0_r.zone_used) begin
      off_c = '0;
    end else if (s0_r.zone_negative) begin
      off_c = offs_c;
    end else begin
      off_c = -offs_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      yr1_r   <= yr_c;
      yl1_r   <= yl_c;
      mon1_r  <= mon_c;
      off1_r  <= off_c;
      day1_r  <= s0_r.day;
      hour1_r <= s0_r.hour;
      min1_r  <= s0_r.minute;
      sec1_r  <= s0_r.second;
      m1_r    <= s0_r.matched;
    end
  end

  // stage 2: year terms
  logic signed [24:0] y365_2_r;
  logic [8:0]         dbm2_r;
  logic signed [15:0] q4_2_r, q100_2_r, q400_2_r;
  logic signed [19:0] off2_r;
  logic [FW-1:0]      day2_r, hour2_r, min2_r, sec2_r;
  logic               m2_r;

  logic signed [15:0] ty_c;

  assign ty_c = yr1_r - 16'sd1970;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      y365_2_r <= 25'(ty_c) * 25'sd365;
      dbm2_r   <= tste_pkg::days_before(mon1_r);
      q4_2_r   <= tste_pkg::tdiv4(yl1_r - 16'sd1968);
      q100_2_r <= tste_pkg::tdiv100(yl1_r - 16'sd1900);
      q400_2_r <= tste_pkg::tdiv400(yl1_r - 16'sd1600);
      off2_r   <= off1_r;
      day2_r   <= day1_r;
      hour2_r  <= hour1_r;
      min2_r   <= min1_r;
      sec2_r   <= sec1_r;
      m2_r     <= m1_r;
    end
  end

  // stage 3: day count
  logic signed [24:0] days3_r;
  logic signed [19:0] off3_r;
  logic [FW-1:0]      hour3_r, min3_r, sec3_r;
  logic               m3_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      days3_r <= y365_2_r + 25'(signed'({1'b0, dbm2_r})) + 25'(q4_2_r) - 25'(q100_2_r)
                 + 25'(q400_2_r) + 25'(signed'({1'b0, day2_r})) - 25'sd1;
      off3_r  <= off2_r;
      hour3_r <= hour2_r;
      min3_r  <= min2_r;
      sec3_r  <= sec2_r;
      m3_r    <= m2_r;
    end
  end

  // stage 4: hours
  logic signed [29:0] t4_r;
  logic signed [19:0] off4_r;
  logic [FW-1:0]      min4_r, sec4_r;
  logic               m4_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      t4_r   <= 30'(days3_r) * 30'sd24 + 30'(signed'({1'b0, hour3_r}));
      off4_r <= off3_r;
      min4_r <= min3_r;
      sec4_r <= sec3_r;
      m4_r   <= m3_r;
    end
  end

  // stage 5: minutes
  logic signed [35:0] t5_r;
  logic signed [19:0] off5_r;
  logic [FW-1:0]      sec5_r;
  logic               m5_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      t5_r   <= 36'(t4_r) * 36'sd60 + 36'(signed'({1'b0, min4_r}));
      off5_r <= off4_r;
      sec5_r <= sec4_r;
      m5_r   <= m4_r;
    end
  end

  // stage 6: seconds
  logic signed [39:0] t6_r;
  logic signed [19:0] off6_r;
  logic               m6_r;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      t6_r   <= 40'(t5_r) * 40'sd60 + 40'(signed'({1'b0, sec5_r}));
      off6_r <= off5_r;
      m6_r   <= m5_r;
    end
  end

  // stage 7: zone offset, result register
  logic [EW-1:0]      epoch7_r;
  logic               m7_r;
  logic signed [39:0] sum_c;

  assign sum_c = t6_r + 40'(off6_r);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      epoch7_r <= m6_r ? sum_c[EW-1:0] : '0;
      m7_r     <= m6_r;
    end
  end

  assign epoch   = epoch7_r;
  assign matched = m7_r;

endmodule

>>> hdl/timestamp_text_to_epoch.sv
// Converts timestamp text "YYYYMMDDhhmmss", optionally followed by whitespace, a sign
// and "hhmm" of zone offset, into seconds since 1970-01-01 UTC. One character is taken
// per cycle while in_tready is high; the request carrying tlast yields one result through an
// eight-stage date arithmetic pipeline, with tuser high when the first fourteen characters
// were digits (otherwise the result is zero). Every character may follow the previous one in
// the next cycle; in_tready drops only when all eight pipeline stages hold results and
// out_tready is low.
module timestamp_text_to_epoch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [38:0] epoch_seconds, [39] zero
  output logic        out_tuser   // matched
);

  tste_pkg::tste_fields_t            fld;
  logic                              take;
  logic [tste_pkg::EPOCH_W-1:0]      epoch;

  assign take = in_tvalid & in_tready;

  tste_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .char_in (in_tdata),
    .last    (in_tlast),
    .fld     (fld)
  );

  tste_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take & in_tlast),
    .fld       (fld),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .epoch     (epoch),
    .matched   (out_tuser)
  );

  assign out_tdata = {1'b0, epoch};

endmodule

>>> hdl/tste_check.sv
module tste_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 40'd0)
    else $error("unmatched result not zero");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

  a_no_result_without_last: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_tvalid && in_tready && in_tlast, 8) && !$past(out_tvalid) && $past(rst_n, 8)
    && !$past(in_tvalid && in_tready && in_tlast, 7) && !$past(in_tvalid && in_tready && in_tlast, 6)
    && !$past(in_tvalid && in_tready && in_tlast, 5) && !$past(in_tvalid && in_tready && in_tlast, 4)
    && !$past(in_tvalid && in_tready && in_tlast, 3) && !$past(in_tvalid && in_tready && in_tlast, 2)
    && !$past(in_tvalid && in_tready && in_tlast, 1) && !$past(out_tvalid, 2)
    && !$past(out_tvalid, 3) && !$past(out_tvalid, 4) && !$past(out_tvalid, 5)
    && !$past(out_tvalid, 6) && !$past(out_tvalid, 7) && !$past(out_tvalid, 8)
    |-> !out_tvalid)
    else $error("result without a last request");

  a_padding: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[39])
    else $error("padding bit set");

endmodule

bind timestamp_text_to_epoch tste_check u_check (.*);

>>> dv/tb_timestamp_text_to_epoch.sv
module tb_timestamp_text_to_epoch;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TOP   = 8'hFF;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    bit         hold;
  } char_req_t;

  typedef struct {
    logic [tste_pkg::EPOCH_W-1:0] epoch;
    logic                         matched;
  } stamp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tuser;

  char_req_t   char_queue[$];
  stamp_t      expected_stamps[$];
  logic [7:0]  text_buf[$];
  int          errors = 0;
  int          idle_in = 0;
  int          calm_in = 0;
  int          stall_out = 0;
  int          calm_out = 0;
  int          month_start[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  tste_pkg::tste_phase_t       scan_phase = tste_pkg::PH_DATE;
  logic [4:0]                  digit_pos = '0;
  logic [tste_pkg::YEAR_W-1:0] year_acc = '0;
  logic [tste_pkg::FLD_W-1:0]  mon_acc = '0;
  logic [tste_pkg::FLD_W-1:0]  day_acc = '0;
  logic [tste_pkg::FLD_W-1:0]  hour_acc = '0;
  logic [tste_pkg::FLD_W-1:0]  min_acc = '0;
  logic [tste_pkg::FLD_W-1:0]  sec_acc = '0;
  logic [tste_pkg::FLD_W-1:0]  zhour_acc = '0;
  logic [tste_pkg::FLD_W-1:0]  zmin_acc = '0;
  logic                        zone_west = 1'b0;

  timestamp_text_to_epoch DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [tste_pkg::EPOCH_W-1:0] epoch_of_fields();
    longint mon;
    longint yr;
    longint r;
    mon = longint'(mon_acc) - 1;
    yr = longint'(year_acc) + mon / 12;
    mon = mon % 12;
    if (mon < 0) begin
      yr = yr - 1;
      mon = mon + 12;
    end
    r = (yr - 1970) * 365 + month_start[int'(mon)];
    if (mon <= 1) yr = yr - 1;
    r = r + (yr - 1968) / 4;
    r = r - (yr - 1900) / 100;
    r = r + (yr - 1600) / 400;
    r = r + longint'(day_acc) - 1;
    r = r * 24 + longint'(hour_acc);
    r = r * 60 + longint'(min_acc);
    r = r * 60 + longint'(sec_acc);
    if (scan_phase == tste_pkg::PH_ZDONE) begin
      if (zone_west) r = r + longint'(zhour_acc) * 3600 + longint'(zmin_acc) * 60;
      else r = r - longint'(zhour_acc) * 3600 - longint'(zmin_acc) * 60;
    end
    return r[tste_pkg::EPOCH_W-1:0];
  endfunction

  task automatic take_char(input logic [7:0] c, input logic fin);
    logic dig;
    logic ws;
    logic [tste_pkg::FLD_W-1:0] d;
    stamp_t s;
    dig = c inside {[CH_ZERO:CH_NINE]};
    ws = c inside {CH_SPACE, [CH_TAB:CH_CR]};
    d = dig ? tste_pkg::FLD_W'(c - CH_ZERO) : '0;
    case (scan_phase)
      tste_pkg::PH_DATE: begin
        if (!dig) begin
          scan_phase = tste_pkg::PH_BAD;
        end else begin
          if (digit_pos < 4) year_acc = tste_pkg::YEAR_W'(year_acc * 10 + d);
          else if (digit_pos < 6) mon_acc = tste_pkg::FLD_W'(mon_acc * 10 + d);
          else if (digit_pos < 8) day_acc = tste_pkg::FLD_W'(day_acc * 10 + d);
          else if (digit_pos < 10) hour_acc = tste_pkg::FLD_W'(hour_acc * 10 + d);
          else if (digit_pos < 12) min_acc = tste_pkg::FLD_W'(min_acc * 10 + d);
          else sec_acc = tste_pkg::FLD_W'(sec_acc * 10 + d);
          digit_pos = digit_pos + 1;
          if (digit_pos >= tste_pkg::DATE_DIGITS) begin
            digit_pos = '0;
            scan_phase = tste_pkg::PH_GAP;
          end
        end
      end
      tste_pkg::PH_GAP: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          zone_west = (c == CH_MINUS);
          digit_pos = '0;
          scan_phase = tste_pkg::PH_ZONE;
        end else if (!ws) begin
          scan_phase = tste_pkg::PH_NOZONE;
        end
      end
      tste_pkg::PH_ZONE: begin
        if (!dig) begin
          scan_phase = tste_pkg::PH_NOZONE;
        end else begin
          if (digit_pos < 2) zhour_acc = tste_pkg::FLD_W'(zhour_acc * 10 + d);
          else zmin_acc = tste_pkg::FLD_W'(zmin_acc * 10 + d);
          digit_pos = digit_pos + 1;
          if (digit_pos >= tste_pkg::ZONE_DIGITS) scan_phase = tste_pkg::PH_ZDONE;
        end
      end
      default: begin
      end
    endcase
    if (fin) begin
      if (scan_phase == tste_pkg::PH_DATE || scan_phase == tste_pkg::PH_BAD) begin
        s.epoch = '0;
        s.matched = 1'b0;
      end else begin
        s.epoch = epoch_of_fields();
        s.matched = 1'b1;
      end
      expected_stamps.push_back(s);
      scan_phase = tste_pkg::PH_DATE;
      digit_pos = '0;
      year_acc = '0;
      mon_acc = '0;
      day_acc = '0;
      hour_acc = '0;
      min_acc = '0;
      sec_acc = '0;
      zhour_acc = '0;
      zmin_acc = '0;
      zone_west = 1'b0;
    end
  endtask

  function automatic int pick_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic add_digits(input int n);
    for (int i = 0; i < n; i++) text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_space();
    int r;
    r = $urandom_range(0, 5);
    text_buf.push_back((r == 5) ? CH_SPACE : CH_TAB + 8'(r));
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) text_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_stamp_text();
    int z;
    add_digits(tste_pkg::DATE_DIGITS);
    z = $urandom_range(0, 3);
    if (z == 0) return;
    if (z == 2) begin
      for (int i = $urandom_range(1, 3); i > 0; i--) add_space();
    end
    text_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    add_digits(tste_pkg::ZONE_DIGITS);
    if (z == 3) add_noise($urandom_range(1, 3));
  endtask

  task automatic post_text(input bit hold);
    char_req_t req;
    for (int i = 0; i < text_buf.size(); i++) begin
      req.ch = text_buf[i];
      req.fin = (i == text_buf.size() - 1);
      req.hold = hold && (i == 0);
      char_queue.push_back(req);
    end
    text_buf.delete();
  endtask

  always @(posedge clk) begin
    logic v_next;
    char_req_t req;
    v_next = in_tvalid;
    if (!rst_n) begin
      v_next = 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_char(in_tdata, in_tlast);
        v_next = 1'b0;
      end
      if (!v_next) begin
        if (idle_in > 0) begin
          idle_in = idle_in - 1;
        end else if (char_queue.size() > 0 &&
                     !(char_queue[0].hold && expected_stamps.size() > 0)) begin
          req = char_queue.pop_front();
          in_tdata <= req.ch;
          in_tlast <= req.fin;
          v_next = 1'b1;
          idle_in = pick_idle(calm_in);
        end
      end
    end
    in_tvalid <= v_next;
  end

  always @(posedge clk) begin
    logic r_next;
    stamp_t want;
    r_next = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_stamps.size() == 0) begin
          $error("unexpected result: epoch_seconds %0d matched %0b",
                 $signed(out_tdata[tste_pkg::EPOCH_W-1:0]), out_tuser);
          errors++;
        end else begin
          want = expected_stamps.pop_front();
          if (out_tdata[tste_pkg::EPOCH_W-1:0] !== want.epoch) begin
            $error("epoch_seconds: expected %0d, actual %0d",
                   $signed(want.epoch), $signed(out_tdata[tste_pkg::EPOCH_W-1:0]));
            errors++;
          end
          if (out_tuser !== want.matched) begin
            $error("matched: expected %0b, actual %0b", want.matched, out_tuser);
            errors++;
          end
          if (out_tdata[39] !== 1'b0) begin
            $error("tdata pad: expected 0, actual %0b", out_tdata[39]);
            errors++;
          end
        end
      end
      if (stall_out > 0) begin
        stall_out = stall_out - 1;
      end else begin
        r_next = 1'b1;
        stall_out = pick_idle(calm_out);
      end
    end
    out_tready <= r_next;
  end

  initial begin
    #12_000_000;
    $display("timestamp_text_to_epoch regression: fail");
    $finish;
  end

  initial begin
    int r;
    int texts;
    add_str("19700101000000");        post_text(0);
    add_str("99991231235959");        post_text(0);
    add_str("00000000000000");        post_text(0);
    add_str("20240229123456+0130");   post_text(0);
    add_str("20240229123456");
    text_buf.push_back(CH_TAB);
    text_buf.push_back(CH_LF);
    text_buf.push_back(CH_VT);
    text_buf.push_back(CH_FF);
    text_buf.push_back(CH_CR);
    text_buf.push_back(CH_SPACE);
    add_str("-9959");                 post_text(0);
    add_str("2024022912345");         post_text(0);
    add_str("2024a229123456");        post_text(0);
    add_str("20241399999999+9999");   post_text(0);
    add_str("20009901000000-0000");   post_text(0);
    add_str("20240101000000+01");     post_text(1);
    add_str("20240101000000 0100");   post_text(0);
    add_str("20240101000000+0100xyz"); post_text(0);
    add_str("20240101000000x+0100");  post_text(0);
    add_str("20240101000000+01a0");   post_text(0);
    add_str("20240101000000-");       post_text(0);
    add_str("2");                     post_text(0);
    add_str("2024");
    text_buf.push_back(CH_NUL);
    add_str("101000000");             post_text(0);
    add_str("20240101000000");
    text_buf.push_back(CH_NUL);
    add_str("+0100");                 post_text(0);
    text_buf.push_back(CH_TOP);
    add_str("9700101000000");         post_text(0);
    add_str("20240101000000   ");     post_text(0);
    add_str("19691231235959-0001");   post_text(1);

    texts = 0;
    while (char_queue.size() < 600 || texts < 40) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_stamp_text();
      end else if (r < 88) begin
        add_stamp_text();
        if ($urandom_range(0, 1)) begin
          r = $urandom_range(1, text_buf.size() - 1);
          while (text_buf.size() > r) void'(text_buf.pop_back());
        end else begin
          text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end else begin
        add_noise($urandom_range(1, 20));
      end
      post_text($urandom_range(0, 29) == 0);
      texts++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (char_queue.size() != 0 || in_tvalid || expected_stamps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("timestamp_text_to_epoch regression: pass");
    end else begin
      $display("timestamp_text_to_epoch regression: fail");
    end
    $finish;
  end

endmodule
